// File: design/mrsv_pkg.sv
package mrsv_pkg;

  // Table capacity; one comparison cell per entry.
  localparam int MAX_REGIONS = 64;
  localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
  localparam int DATA_W      = 64;
  localparam int STEP_W      = $clog2(DATA_W);
  localparam int OUT_CNT_W   = 7;

  // Configuration register indexes.
  localparam int          CFG_IDX_W           = 3;
  localparam logic [2:0]  CFG_GRANULE         = 3'd0;
  localparam logic [2:0]  CFG_GUEST_ISA       = 3'd1;
  localparam logic [2:0]  CFG_AUTH_NONCE      = 3'd2;
  localparam logic [2:0]  CFG_AUTH_IDENTITY   = 3'd3;
  localparam logic [2:0]  CFG_GENERATION      = 3'd4;
  localparam logic [2:0]  CFG_KIND_ANON       = 3'd5;
  localparam logic [2:0]  CFG_KIND_FILE       = 3'd6;

  localparam logic        CMD_BEGIN  = 1'b0;
  localparam logic        CMD_RECORD = 1'b1;

  localparam logic [31:0] ISA_A          = 32'd1;
  localparam logic [31:0] ISA_B          = 32'd2;
  localparam logic [31:0] PROT_READ_BIT  = 32'd1;
  localparam logic [31:0] PROT_ALL_BITS  = 32'd7;

  typedef enum logic [3:0] {
    ERR_NONE     = 4'd0,
    ERR_HEADER   = 4'd1,
    ERR_TOO_MANY = 4'd2,
    ERR_ZERO     = 4'd3,
    ERR_ALIGN    = 4'd4,
    ERR_WRAP     = 4'd5,
    ERR_PROT     = 4'd6,
    ERR_FLAGS    = 4'd7,
    ERR_KIND     = 4'd8,
    ERR_ANON     = 4'd9,
    ERR_FILE     = 4'd10,
    ERR_DUP      = 4'd11,
    ERR_OVERLAP  = 4'd12
  } err_t;

  typedef enum logic [1:0] {
    HIT_NONE = 2'd0,
    HIT_DUP  = 2'd1,
    HIT_OVL  = 2'd2
  } hit_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

  // Probe word handed from cell to cell.
  typedef struct packed {
    logic              vld;
    logic [DATA_W-1:0] rid;
    logic [DATA_W-1:0] addr;
    logic [DATA_W-1:0] pend;
    hit_t              hit;
  } probe_t;

endpackage

// File: design/mrsv_rem.sv
module mrsv_rem (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [mrsv_pkg::DATA_W-1:0] dividend,
  input  logic [mrsv_pkg::DATA_W-1:0] divisor,
  output logic                      busy,
  output logic                      aligned
);
  import mrsv_pkg::*;

  logic              busy_r;
  logic [STEP_W-1:0] step_r;
  logic [DATA_W-1:0] dvd_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] rem_nxt;
  logic [DATA_W:0]   rem_sh;
  logic              zero_r;

  // One restoring step per cycle: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    rem_sh = {rem_r, dvd_r[DATA_W-1]};
    if (rem_sh >= {1'b0, divisor}) begin
      rem_nxt = DATA_W'(rem_sh - {1'b0, divisor});
    end else begin
      rem_nxt = rem_sh[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + 1'b1;
      if (step_r == STEP_W'(DATA_W - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r  <= dividend;
      rem_r  <= '0;
      zero_r <= (dividend == '0);
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DATA_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign busy    = busy_r;
  // A zero unit only aligns zero.
  assign aligned = (divisor == '0) ? zero_r : (rem_r == '0);

endmodule

// File: design/mrsv_cell.sv
module mrsv_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mrsv_pkg::probe_t            probe_i,
  input  logic                        occupied,
  input  logic                        wr_en,
  input  logic [mrsv_pkg::DATA_W-1:0] wr_start,
  input  logic [mrsv_pkg::DATA_W-1:0] wr_end,
  input  logic [mrsv_pkg::DATA_W-1:0] wr_rid,
  output mrsv_pkg::probe_t            probe_o
);
  import mrsv_pkg::*;

  logic [DATA_W-1:0] start_r;
  logic [DATA_W-1:0] end_r;
  logic [DATA_W-1:0] rid_r;
  probe_t            probe_r;
  probe_t            probe_nxt;

  // Mark the first conflict only; a later cell never overrides it.
  always_comb begin
    probe_nxt = probe_i;
    if (probe_i.vld && occupied && probe_i.hit == HIT_NONE) begin
      if (probe_i.rid == rid_r) begin
        probe_nxt.hit = HIT_DUP;
      end else if (probe_i.addr < end_r && start_r < probe_i.pend) begin
        probe_nxt.hit = HIT_OVL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r.vld <= 1'b0;
    end else begin
      probe_r <= probe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      start_r <= wr_start;
      end_r   <= wr_end;
      rid_r   <= wr_rid;
    end
  end

  assign probe_o = probe_r;

endmodule

// File: design/mapping_region_set_validator_core.sv
// Mapping region set validator.
// Commands enter on the in_ ports and are taken at a clock edge where start
// is high and busy is low. A begin command (in_command low) empties the
// region table and checks the header registers; a record command checks one
// mapping record and, if clean, stores it in the next free table entry.
// Every command yields exactly one result word, shown on the out_ ports for
// one cycle with out_valid high: set_ok, the sticky first error and the
// number of stored records. The receiver cannot stall; a word is gone after
// its cycle.
// Begin, a record after an error and a record into a full table answer
// in the cycle after they are taken. A checked record waits for the
// 64-step remainder units for the alignment checks and, alongside, the chain
// of MAX_REGIONS comparison cells that the record walks, one cell per cycle.
// One command at a time; busy stays high while a record is checked, and the
// next command may be taken in the cycle its result is shown.
// The user writes configuration through cfg_we / cfg_index / cfg_wdata while
// the block is idle; the block does not enforce it. Unlisted indexes are dropped.
// Reset restores the register defaults, clears the count and the error.
module mapping_region_set_validator_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic [mrsv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_wdata,
  // commands
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_command,
  input  logic [63:0]                   in_reservation_id,
  input  logic [63:0]                   in_address,
  input  logic [63:0]                   in_length,
  input  logic [63:0]                   in_source_identity,
  input  logic [63:0]                   in_source_offset,
  input  logic [31:0]                   in_source_kind,
  input  logic [31:0]                   in_protection,
  input  logic [31:0]                   in_flag_bits,
  input  logic [31:0]                   in_reserved_word,
  // results
  output logic                          out_valid,
  output logic                          out_set_ok,
  output logic [3:0]                    out_error_code,
  output logic [6:0]                    out_records_accepted
);
  import mrsv_pkg::*;

  // configuration registers
  logic [63:0] granule_r;
  logic [31:0] guest_isa_r;
  logic [63:0] auth_nonce_r;
  logic [63:0] auth_identity_r;
  logic [63:0] generation_r;
  logic [31:0] kind_anon_r;
  logic [31:0] kind_file_r;

  // control state
  state_t           state_r, state_nxt;
  err_t             first_error_r, first_error_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             rec_go;
  logic             store;
  logic             chain_done_r;
  hit_t             chain_hit_r;

  // record held while it is checked
  logic [63:0] rid_r, addr_r, len_r, sid_r, soff_r;
  logic [31:0] kind_r, prot_r, flg_r, rsv_r;

  logic   hdr_ok;
  err_t   rec_err;
  logic   addr_al, len_al, soff_al;
  logic   addr_busy, len_busy, soff_busy;
  logic   run_done;
  logic [64:0] addr_end;
  logic [64:0] soff_end;

  probe_t probe_head;
  probe_t chain_w [MAX_REGIONS+1];

  // Config write port; no read-back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      granule_r       <= 64'd4096;
      guest_isa_r     <= 32'd1;
      auth_nonce_r    <= '0;
      auth_identity_r <= '0;
      generation_r    <= '0;
      kind_anon_r     <= '0;
      kind_file_r     <= 32'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRANULE:       granule_r       <= cfg_wdata;
        CFG_GUEST_ISA:     guest_isa_r     <= cfg_wdata[31:0];
        CFG_AUTH_NONCE:    auth_nonce_r    <= cfg_wdata;
        CFG_AUTH_IDENTITY: auth_identity_r <= cfg_wdata;
        CFG_GENERATION:    generation_r    <= cfg_wdata;
        CFG_KIND_ANON:     kind_anon_r     <= cfg_wdata[31:0];
        CFG_KIND_FILE:     kind_file_r     <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // Header: ISA 1 or 2, granule a nonzero power of two, nonce, identity and generation nonzero.
  assign hdr_ok = (guest_isa_r == ISA_A || guest_isa_r == ISA_B)
               && (granule_r != '0) && ((granule_r & (granule_r - 64'd1)) == '0)
               && (auth_nonce_r != '0) && (auth_identity_r != '0)
               && (generation_r != '0);

  // Carry out of the 65-bit sums flags an end past the address space.
  assign addr_end = {1'b0, addr_r} + {1'b0, len_r};
  assign soff_end = {1'b0, soff_r} + {1'b0, len_r};

  // Record checks in priority order; the table walk result comes last.
  always_comb begin
    rec_err = ERR_NONE;
    if (rid_r == '0 || addr_r == '0 || len_r == '0) begin
      rec_err = ERR_ZERO;
    end else if (!addr_al || !len_al) begin
      rec_err = ERR_ALIGN;
    end else if (addr_end[64]) begin
      rec_err = ERR_WRAP;
    end else if ((prot_r & PROT_READ_BIT) == '0 || (prot_r & ~PROT_ALL_BITS) != '0) begin
      rec_err = ERR_PROT;
    end else if (flg_r != '0 || rsv_r != '0) begin
      rec_err = ERR_FLAGS;
    end else if (kind_r == kind_anon_r) begin
      // equal kind codes fall here: anonymous wins
      if (sid_r != '0 || soff_r != '0) begin
        rec_err = ERR_ANON;
      end
    end else if (kind_r == kind_file_r) begin
      if (sid_r == '0 || !soff_al || soff_end[64]) begin
        rec_err = ERR_FILE;
      end
    end else begin
      rec_err = ERR_KIND;
    end
    if (rec_err == ERR_NONE) begin
      if (chain_hit_r == HIT_DUP) begin
        rec_err = ERR_DUP;
      end else if (chain_hit_r == HIT_OVL) begin
        rec_err = ERR_OVERLAP;
      end
    end
  end

  assign run_done = chain_done_r && !addr_busy && !len_busy && !soff_busy;

  // Sequencer: take a command, answer it directly or launch the record walk, then store or flag the record when done.
  always_comb begin
    state_nxt       = state_r;
    first_error_nxt = first_error_r;
    count_nxt       = count_r;
    out_valid_nxt   = 1'b0;
    rec_go          = 1'b0;
    store           = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_command == CMD_BEGIN) begin
            count_nxt       = '0;
            first_error_nxt = hdr_ok ? ERR_NONE : ERR_HEADER;
            out_valid_nxt   = 1'b1;
          end else if (first_error_r != ERR_NONE) begin
            // sticky error: repeat it, check nothing
            out_valid_nxt = 1'b1;
          end else if (count_r >= CNT_W'(MAX_REGIONS)) begin
            first_error_nxt = ERR_TOO_MANY;
            out_valid_nxt   = 1'b1;
          end else begin
            rec_go    = 1'b1;
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (run_done) begin
          if (rec_err == ERR_NONE) begin
            store     = 1'b1;
            count_nxt = count_r + 1'b1;
          end else begin
            first_error_nxt = rec_err;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      first_error_r <= ERR_NONE;
      count_r       <= '0;
      out_valid_r   <= 1'b0;
      chain_done_r  <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      first_error_r <= first_error_nxt;
      count_r       <= count_nxt;
      out_valid_r   <= out_valid_nxt;
      if (rec_go) begin
        chain_done_r <= 1'b0;
      end else if (chain_w[MAX_REGIONS].vld) begin
        chain_done_r <= 1'b1;
      end
    end
  end

  // Hold the record and the walk verdict.
  always_ff @(posedge clk) begin
    if (rec_go) begin
      rid_r  <= in_reservation_id;
      addr_r <= in_address;
      len_r  <= in_length;
      sid_r  <= in_source_identity;
      soff_r <= in_source_offset;
      kind_r <= in_source_kind;
      prot_r <= in_protection;
      flg_r  <= in_flag_bits;
      rsv_r  <= in_reserved_word;
    end
    if (chain_w[MAX_REGIONS].vld) begin
      chain_hit_r <= chain_w[MAX_REGIONS].hit;
    end
  end

  // Alignment: three remainder units run in parallel with the table walk.
  mrsv_rem u_rem_addr (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rec_go),
    .dividend (in_address),
    .divisor  (granule_r),
    .busy     (addr_busy),
    .aligned  (addr_al)
  );

  mrsv_rem u_rem_len (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rec_go),
    .dividend (in_length),
    .divisor  (granule_r),
    .busy     (len_busy),
    .aligned  (len_al)
  );

  mrsv_rem u_rem_soff (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rec_go),
    .dividend (in_source_offset),
    .divisor  (granule_r),
    .busy     (soff_busy),
    .aligned  (soff_al)
  );

  // Inject the probe into the head of the chain on launch.
  always_comb begin
    probe_head.vld  = rec_go;
    probe_head.rid  = in_reservation_id;
    probe_head.addr = in_address;
    probe_head.pend = in_address + in_length;
    probe_head.hit  = HIT_NONE;
  end

  assign chain_w[0] = probe_head;

  // Region table: one cell per entry, walked in table order.
  for (genvar gi = 0; gi < MAX_REGIONS; gi++) begin : g_cell
    logic occupied;
    logic wr_en;

    assign occupied = (CNT_W'(gi) < count_r);
    assign wr_en    = store && (count_r == CNT_W'(gi));

    mrsv_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .probe_i  (chain_w[gi]),
      .occupied (occupied),
      .wr_en    (wr_en),
      .wr_start (addr_r),
      .wr_end   (addr_end[63:0]),
      .wr_rid   (rid_r),
      .probe_o  (chain_w[gi+1])
    );
  end

  assign busy                 = (state_r != ST_IDLE);
  assign out_valid            = out_valid_r;
  assign out_set_ok           = (first_error_r == ERR_NONE);
  assign out_error_code       = first_error_r;
  assign out_records_accepted = OUT_CNT_W'(count_r);

endmodule
